// ----- hw/rtl/edr_pkg.sv -----
`default_nettype none
package edr_pkg;

	localparam int QDEPTH = 4;
	localparam logic [6:0] DIM_RESET = 7'd64;
	localparam logic [6:0] COUNT_MAX = 7'd127;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ROW  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [5:0]        elem_index;
		logic signed [15:0] elem_value;
		logic              row_last;
	} in_item_t;

	typedef struct packed {
		logic [18:0] distance;
		logic [37:0] sum_squares;
		logic        length_error;
	} out_item_t;

	// one finished row, handed from the accumulator to the root unit
	typedef struct packed {
		logic [37:0] sum_squares;
		logic        length_error;
	} row_sum_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_HOLD
	} back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/euclidean_distance_to_rows.sv -----
`default_nettype none
// Streams matrix rows one element per cycle (while full is low) against a stored
// query vector and returns, for each row, the sum of squared differences, its
// floor square root and a length error flag. The front end takes one item
// (query load or row element) every cycle that full is low, through a
// three-stage read/subtract/square pipeline into a running sum; finished rows
// enter a four-entry queue. The back end computes the square root one result
// bit per cycle, one row at a time, and takes the next row from the queue only
// after the current result has moved to the output register; rows that end
// faster than that fill the queue and hold off the front end through full.
// full is raised while four row ends are queued or in flight.
module euclidean_distance_to_rows
	import edr_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire in_item_t   item,
	output logic            empty,
	input  wire logic       pop,
	output out_item_t       result,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);
	logic     q_wr, q_rd, q_empty;
	row_sum_t q_wdata, q_rdata;

	edr_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.q_rd      (q_rd)
	);

	edr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	edr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rdata (q_rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/edr_ram.sv -----
`default_nettype none
module edr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/edr_front.sv -----
`default_nettype none
module edr_front
	import edr_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	input  wire logic     cfg_we,
	input  wire logic [6:0] cfg_wdata,
	output logic          q_wr,
	output row_sum_t      q_wdata,
	input  wire logic     q_rd
);
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PW = $clog2(QDEPTH) + 1;

	logic [6:0]    dim_q;
	logic [6:0]    cnt_q;
	logic [PW-1:0] pend_q;
	logic [37:0]   sum_q;

	logic          accept, is_row, is_load;
	logic [6:0]    cnt_inc;
	logic          in_range, err;
	logic [15:0]   rd_data;

	logic          valid_s1, use_s1, last_s1, err_s1;
	logic [15:0]   value_s1;
	logic          valid_s2, last_s2, err_s2;
	logic [15:0]   abs_s2;
	logic          valid_s3, last_s3, err_s3;
	logic [31:0]   sq_s3;

	logic [16:0]   diff;
	logic [38:0]   sum_wide;
	logic [37:0]   sum_sat;

	assign accept  = push && !full;
	assign is_row  = accept && (item.command == CMD_ROW);
	assign is_load = accept && (item.command == CMD_LOAD) && (32'(item.elem_index) < MAX_DIM);

	// space is reserved for every row end still in flight toward the queue
	assign full = (pend_q == PW'(QDEPTH));

	assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 7'd1;
	assign in_range = (32'(cnt_q) < 32'(dim_q)) && (32'(cnt_q) < MAX_DIM);
	assign err      = (cnt_inc != dim_q) || (dim_q == 7'd0) || (32'(dim_q) > MAX_DIM);

	edr_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_query (
		.clk   (clk),
		.we    (is_load),
		.waddr (AW'(item.elem_index)),
		.wdata (item.elem_value),
		.raddr (AW'(cnt_q)),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= DIM_RESET;
			cnt_q  <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_we) begin
				dim_q <= cfg_wdata;
			end
			if (is_row) begin
				cnt_q <= item.row_last ? 7'd0 : cnt_inc;
			end
			case ({is_row && item.row_last, q_rd})
				2'b10:   pend_q <= pend_q + PW'(1);
				2'b01:   pend_q <= pend_q - PW'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= is_row;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign diff = {value_s1[15], value_s1} - {rd_data[15], rd_data};

	always_ff @(posedge clk) begin
		value_s1 <= item.elem_value;
		use_s1   <= in_range;
		last_s1  <= item.row_last;
		err_s1   <= err;

		// |diff| is at most 65535, so 16 bits hold it
		if (!use_s1) begin
			abs_s2 <= '0;
		end else if (diff[16]) begin
			abs_s2 <= 16'(-diff);
		end else begin
			abs_s2 <= diff[15:0];
		end
		last_s2 <= last_s1;
		err_s2  <= err_s1;

		sq_s3   <= 32'(abs_s2) * 32'(abs_s2);
		last_s3 <= last_s2;
		err_s3  <= err_s2;
	end

	assign sum_wide = {1'b0, sum_q} + 39'(sq_s3);
	assign sum_sat  = sum_wide[38] ? '1 : sum_wide[37:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s3) begin
			sum_q <= last_s3 ? 38'd0 : sum_sat;
		end
	end

	assign q_wr                 = valid_s3 && last_s3;
	assign q_wdata.sum_squares  = sum_sat;
	assign q_wdata.length_error = err_s3;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(QDEPTH))
		else $error("row-end reservation count overran the queue depth");

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && last_s3 |=> sum_q == 38'd0)
		else $error("sum not cleared after row end");

	a_row_flow: assert property (@(posedge clk) disable iff (!arst_n)
		is_row |-> ##3 valid_s3)
		else $error("row item lost in the front pipeline");
endmodule
`default_nettype wire

// ----- hw/rtl/edr_fifo.sv -----
`default_nettype none
module edr_fifo
	import edr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  wire row_sum_t wdata,
	input  wire logic     rd,
	output row_sum_t      rdata,
	output logic          empty
);
	localparam int AW = $clog2(QDEPTH);

	row_sum_t    mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + AW'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && !rd && cnt_q == (AW+1)'(QDEPTH)) && !(rd && empty))
		else $error("row queue overflow or underflow");
endmodule
`default_nettype wire

// ----- hw/rtl/edr_back.sv -----
`default_nettype none
module edr_back
	import edr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire row_sum_t q_rdata,
	input  wire logic     q_empty,
	output logic          q_rd,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);
	back_state_t state_q, state_nxt;

	logic [37:0] rem_q, sum_q;
	logic [39:0] root_q;
	logic [38:0] bit_q;
	logic        err_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [39:0] trial;
	logic        ge;
	logic        load, step, emit;

	// bit-pair restoring square root, one result bit per cycle
	assign trial = root_q + {1'b0, bit_q};
	assign ge    = {2'b0, rem_q} >= trial;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty) state_nxt = BK_CALC;
			BK_CALC: if (bit_q[0]) state_nxt = BK_HOLD;
			BK_HOLD: if (!out_valid_q) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		load = 1'b0;
		step = 1'b0;
		emit = 1'b0;
		case (state_q)
			BK_IDLE: load = !q_empty;
			BK_CALC: step = 1'b1;
			BK_HOLD: emit = !out_valid_q;
			default: ;
		endcase
	end

	assign q_rd = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= q_rdata.sum_squares;
			sum_q  <= q_rdata.sum_squares;
			err_q  <= q_rdata.length_error;
			root_q <= '0;
			bit_q  <= 39'd1 << 38;
		end else if (step) begin
			if (ge) begin
				rem_q  <= rem_q - trial[37:0];
				root_q <= (root_q >> 1) + {1'b0, bit_q};
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (emit) begin
			out_q.distance     <= root_q[18:0];
			out_q.sum_squares  <= sum_q;
			out_q.length_error <= err_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	a_calc_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CALC |-> $onehot(bit_q))
		else $error("root step bit lost");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_HOLD |-> bit_q == '0 && root_q[39:19] == '0)
		else $error("root not finished or out of range");
endmodule
`default_nettype wire
